// ===== design/tphc_pkg.sv =====
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared constants and helpers for the environmental compensation pipeline.
// ----------------------------------------------------------------------------
package tphc_pkg;

   localparam int unsigned DIV_WIDTH  = 32;
   localparam int unsigned SIDE_WIDTH = 35;

   localparam logic [2:0] CSR_TEMP       = 3'd0;
   localparam logic [2:0] CSR_PRESS_LOW  = 3'd1;
   localparam logic [2:0] CSR_PRESS_HIGH = 3'd2;
   localparam logic [2:0] CSR_MISC       = 3'd3;
   localparam logic [2:0] CSR_HUM_SHAPE  = 3'd4;

   localparam logic [31:0] PRESS_OFFSET  = 32'd64000;
   localparam logic [31:0] PRESS_BASE    = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE   = 32'd3125;
   localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
   localparam logic [31:0] HUM_OFFSET    = 32'd76800;
   localparam logic [31:0] HUM_MAX       = 32'd419430400;
   localparam logic [31:0] HUM_BIAS      = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_A   = 32'd16384;
   localparam logic [31:0] ONE_Q15       = 32'd32768;
   localparam logic [31:0] HUM_ROUND_B   = 32'd8192;
   localparam logic [31:0] TEMP_ROUND    = 32'd128;
   localparam logic [31:0] PRESS_SAT     = 32'd131071;

   typedef struct packed {
      logic [15:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [15:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
      logic [7:0]  h1;
      logic [31:0] h2;
      logic [7:0]  h3;
      logic [31:0] h4;
      logic [31:0] h5;
      logic [31:0] h6;
   } coeff_type;

   function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
      sra = $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] x);
      sx16 = {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] x);
      sx12 = {{20{x[11]}}, x};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] x);
      sx8 = {{24{x[7]}}, x};
   endfunction

endpackage

// ===== design/temp_press_hum_compensation.sv =====
// ----------------------------------------------------------------------------
// temp_press_hum_compensation
// Temperature, pressure and humidity compensation from packed calibration
// coefficients, as a fully pipelined datapath.
// Stages: 10 front, 32 divider and 3 pressure finish stages between req
// accept and rsp_tvalid. Throughput: one item per cycle; the whole
// pipeline holds while a result waits on rsp_tready.
// Reset: synchronous, clears valid bits and zeroes all coefficients.
// ----------------------------------------------------------------------------
module temp_press_hum_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // raw_temperature, raw_pressure, raw_humidity
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // temperature_centi, pressure_pa, humidity_q10, pad
   output logic        rsp_tuser,   // pressure_fault
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] temp_ff;
   logic [63:0] plow_ff, phigh_ff;
   logic [55:0] misc_ff;
   logic [23:0] hshape_ff;
   tphc_pkg::coeff_type cf;

   logic en;
   logic f_valid, f_shift;
   logic [31:0] f_num, f_den;
   logic [15:0] f_tout;
   logic [16:0] f_hout;
   logic d_valid;
   logic [31:0] d_quo;
   logic [tphc_pkg::SIDE_WIDTH-1:0] d_side;

   logic [2:0]  pv_ff;
   logic [31:0] p1_p_ff, p1_ms_ff, p1_m8_ff;
   logic [31:0] p2_p_ff, p2_x_ff, p2_b_ff;
   logic [2:0]  fault_ff;
   logic [15:0] tout_ff [3];
   logic [16:0] hout_ff [3];
   logic [16:0] p3_pout_ff;
   logic [31:0] pq, pfin;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff   <= '0;
         plow_ff   <= '0;
         phigh_ff  <= '0;
         misc_ff   <= '0;
         hshape_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            tphc_pkg::CSR_TEMP:       temp_ff   <= csr_wdata[47:0];
            tphc_pkg::CSR_PRESS_LOW:  plow_ff   <= csr_wdata;
            tphc_pkg::CSR_PRESS_HIGH: phigh_ff  <= csr_wdata;
            tphc_pkg::CSR_MISC:       misc_ff   <= csr_wdata[55:0];
            tphc_pkg::CSR_HUM_SHAPE:  hshape_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cf.t1 = temp_ff[15:0];
      cf.t2 = tphc_pkg::sx16(temp_ff[31:16]);
      cf.t3 = tphc_pkg::sx16(temp_ff[47:32]);
      cf.p1 = plow_ff[15:0];
      cf.p2 = tphc_pkg::sx16(plow_ff[31:16]);
      cf.p3 = tphc_pkg::sx16(plow_ff[47:32]);
      cf.p4 = tphc_pkg::sx16(plow_ff[63:48]);
      cf.p5 = tphc_pkg::sx16(phigh_ff[15:0]);
      cf.p6 = tphc_pkg::sx16(phigh_ff[31:16]);
      cf.p7 = tphc_pkg::sx16(phigh_ff[47:32]);
      cf.p8 = tphc_pkg::sx16(phigh_ff[63:48]);
      cf.p9 = tphc_pkg::sx16(misc_ff[15:0]);
      cf.h1 = misc_ff[23:16];
      cf.h2 = tphc_pkg::sx16(misc_ff[39:24]);
      cf.h3 = misc_ff[47:40];
      cf.h6 = tphc_pkg::sx8(misc_ff[55:48]);
      cf.h4 = tphc_pkg::sx12(hshape_ff[11:0]);
      cf.h5 = tphc_pkg::sx12(hshape_ff[23:12]);
   end

   assign en         = !pv_ff[2] || rsp_tready;
   assign req_tready = en;

   tphc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .adt       (req_tdata[19:0]),
      .adp       (req_tdata[39:20]),
      .adh       (req_tdata[55:40]),
      .cf        (cf),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_shift (f_shift),
      .out_tout  (f_tout),
      .out_hout  (f_hout)
   );

   tphc_divider #(
      .SIDE_WIDTH (tphc_pkg::SIDE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   ({f_hout, f_tout, (f_den == '0), f_shift}),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[1:0], d_valid};
      end
   end

   always_comb begin
      pq   = d_side[0] ? {d_quo[30:0], 1'b0} : d_quo;
      pfin = p2_p_ff + tphc_pkg::sra(tphc_pkg::sra(p2_x_ff, 5'd12) + p2_b_ff + cf.p7, 5'd4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_p_ff    <= pq;
         p1_ms_ff   <= {3'd0, pq[31:3]} * {3'd0, pq[31:3]};
         p1_m8_ff   <= {2'd0, pq[31:2]} * cf.p8;
         fault_ff   <= {fault_ff[1:0], d_side[1]};
         tout_ff[0] <= d_side[17:2];
         hout_ff[0] <= d_side[34:18];
         tout_ff[1] <= tout_ff[0];
         hout_ff[1] <= hout_ff[0];
         tout_ff[2] <= tout_ff[1];
         hout_ff[2] <= hout_ff[1];

         p2_p_ff    <= p1_p_ff;
         p2_x_ff    <= cf.p9 * {13'd0, p1_ms_ff[31:13]};
         p2_b_ff    <= tphc_pkg::sra(p1_m8_ff, 5'd13);

         if (fault_ff[1]) begin
            p3_pout_ff <= '0;
         end else if (pfin > tphc_pkg::PRESS_SAT) begin
            p3_pout_ff <= tphc_pkg::PRESS_SAT[16:0];
         end else begin
            p3_pout_ff <= pfin[16:0];
         end
      end
   end

   assign rsp_tvalid = pv_ff[2];
   assign rsp_tuser  = fault_ff[2];
   assign rsp_tdata  = {6'd0, hout_ff[2], p3_pout_ff, tout_ff[2]};

endmodule

// ===== design/tphc_front.sv =====
// ----------------------------------------------------------------------------
// tphc_front
// Ten-stage front end: temperature, humidity and the pressure divisor and
// dividend, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module tphc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [19:0]         adt,
   input  logic [19:0]         adp,
   input  logic [15:0]         adh,
   input  tphc_pkg::coeff_type cf,
   output logic                out_valid,
   output logic [31:0]         out_num,
   output logic [31:0]         out_den,
   output logic                out_shift,
   output logic [15:0]         out_tout,
   output logic [16:0]         out_hout
);

   logic [9:0] valid_ff;

   logic [31:0] x1, dt;
   logic [31:0] s1_m1_ff, s1_dd_ff;
   logic [19:0] s1_adp_ff, s2_adp_ff, s3_adp_ff, s4_adp_ff, s5_adp_ff, s6_adp_ff;
   logic [15:0] s1_adh_ff, s2_adh_ff, s3_adh_ff;
   logic [31:0] s2_a_ff, s2_m3_ff;
   logic [31:0] s3_tf_ff;
   logic [31:0] t5, tr, pa, pd, hv;
   logic [15:0] tsat;
   logic [15:0] s4_tout_ff, s5_tout_ff, s6_tout_ff, s7_tout_ff, s8_tout_ff, s9_tout_ff;
   logic [15:0] s10_tout_ff;
   logic [31:0] s4_mdd_ff, s4_m5_ff, s4_m2a_ff, s4_mq_ff, s4_mr_ff, s4_m5v_ff;
   logic [15:0] s4_adh_ff;
   logic [31:0] hq, hr, ha;
   logic [31:0] s5_b0_ff, s5_m3p_ff, s5_b1_ff, s5_m2a_ff, s5_ha_ff, s5_mqr_ff;
   logic [31:0] s6_b_ff, s6_a_ff, s6_mh_ff, s6_ha_ff;
   logic [31:0] s7_m_ff, s7_pn_ff, s7_mv_ff;
   logic [31:0] den;
   logic [31:0] s8_den_ff, s8_num_ff, s8_hmdd_ff, s8_mv_ff;
   logic        s8_shift_ff, s9_shift_ff, s10_shift_ff;
   logic [31:0] s9_den_ff, s9_num_ff, s9_mh1_ff, s9_mv_ff;
   logic [31:0] hfin;
   logic [31:0] s10_den_ff, s10_num_ff;
   logic [16:0] s10_hout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[8:0], in_valid};
      end
   end

   always_comb begin
      x1   = {15'd0, adt[19:3]} - {15'd0, cf.t1, 1'b0};
      dt   = {16'd0, adt[19:4]} - {16'd0, cf.t1};
      t5   = {s3_tf_ff[29:0], 2'b00} + s3_tf_ff;
      tr   = tphc_pkg::sra(t5 + tphc_pkg::TEMP_ROUND, 5'd8);
      if ($signed(tr) < -32'sd32768) begin
         tsat = 16'h8000;
      end else if ($signed(tr) > 32'sd32767) begin
         tsat = 16'h7FFF;
      end else begin
         tsat = tr[15:0];
      end
      pa   = tphc_pkg::sra(s3_tf_ff, 5'd1) - tphc_pkg::PRESS_OFFSET;
      pd   = tphc_pkg::sra(pa, 5'd2);
      hv   = s3_tf_ff - tphc_pkg::HUM_OFFSET;
      hq   = tphc_pkg::sra(s4_mq_ff, 5'd10);
      hr   = tphc_pkg::sra(s4_mr_ff, 5'd11) + tphc_pkg::ONE_Q15;
      ha   = tphc_pkg::sra((({2'b00, s4_adh_ff, 14'd0} - {cf.h4[11:0], 20'd0})
                             - s4_m5v_ff) + tphc_pkg::HUM_ROUND_A, 5'd15);
      den  = tphc_pkg::sra(s7_m_ff, 5'd15);
      hfin = s9_mv_ff - tphc_pkg::sra(s9_mh1_ff, 5'd4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_m1_ff    <= x1 * cf.t2;
         s1_dd_ff    <= dt * dt;
         s1_adp_ff   <= adp;
         s1_adh_ff   <= adh;

         s2_a_ff     <= tphc_pkg::sra(s1_m1_ff, 5'd11);
         s2_m3_ff    <= tphc_pkg::sra(s1_dd_ff, 5'd12) * cf.t3;
         s2_adp_ff   <= s1_adp_ff;
         s2_adh_ff   <= s1_adh_ff;

         s3_tf_ff    <= s2_a_ff + tphc_pkg::sra(s2_m3_ff, 5'd14);
         s3_adp_ff   <= s2_adp_ff;
         s3_adh_ff   <= s2_adh_ff;

         s4_tout_ff  <= tsat;
         s4_mdd_ff   <= pd * pd;
         s4_m5_ff    <= pa * cf.p5;
         s4_m2a_ff   <= cf.p2 * pa;
         s4_mq_ff    <= hv * cf.h6;
         s4_mr_ff    <= hv * {24'd0, cf.h3};
         s4_m5v_ff   <= cf.h5 * hv;
         s4_adp_ff   <= s3_adp_ff;
         s4_adh_ff   <= s3_adh_ff;

         s5_b0_ff    <= tphc_pkg::sra(s4_mdd_ff, 5'd11) * cf.p6;
         s5_m3p_ff   <= cf.p3 * tphc_pkg::sra(s4_mdd_ff, 5'd13);
         s5_b1_ff    <= {s4_m5_ff[30:0], 1'b0};
         s5_m2a_ff   <= s4_m2a_ff;
         s5_ha_ff    <= ha;
         s5_mqr_ff   <= hq * hr;
         s5_adp_ff   <= s4_adp_ff;
         s5_tout_ff  <= s4_tout_ff;

         s6_b_ff     <= tphc_pkg::sra(s5_b0_ff + s5_b1_ff, 5'd2) + {cf.p4[15:0], 16'd0};
         s6_a_ff     <= tphc_pkg::sra(tphc_pkg::sra(s5_m3p_ff, 5'd3)
                                      + tphc_pkg::sra(s5_m2a_ff, 5'd1), 5'd18);
         s6_mh_ff    <= (tphc_pkg::sra(s5_mqr_ff, 5'd10) + tphc_pkg::HUM_BIAS) * cf.h2;
         s6_ha_ff    <= s5_ha_ff;
         s6_adp_ff   <= s5_adp_ff;
         s6_tout_ff  <= s5_tout_ff;

         s7_m_ff     <= (tphc_pkg::ONE_Q15 + s6_a_ff) * {16'd0, cf.p1};
         s7_pn_ff    <= ((tphc_pkg::PRESS_BASE - {12'd0, s6_adp_ff})
                         - tphc_pkg::sra(s6_b_ff, 5'd12)) * tphc_pkg::PRESS_SCALE;
         s7_mv_ff    <= s6_ha_ff * tphc_pkg::sra(s6_mh_ff + tphc_pkg::HUM_ROUND_B, 5'd14);
         s7_tout_ff  <= s6_tout_ff;

         s8_den_ff   <= den;
         s8_shift_ff <= s7_pn_ff >= tphc_pkg::SIGN_BIT;
         s8_num_ff   <= (s7_pn_ff >= tphc_pkg::SIGN_BIT) ? s7_pn_ff
                                                         : {s7_pn_ff[30:0], 1'b0};
         s8_hmdd_ff  <= tphc_pkg::sra(s7_mv_ff, 5'd15) * tphc_pkg::sra(s7_mv_ff, 5'd15);
         s8_mv_ff    <= s7_mv_ff;
         s8_tout_ff  <= s7_tout_ff;

         s9_mh1_ff   <= tphc_pkg::sra(s8_hmdd_ff, 5'd7) * {24'd0, cf.h1};
         s9_mv_ff    <= s8_mv_ff;
         s9_den_ff   <= s8_den_ff;
         s9_num_ff   <= s8_num_ff;
         s9_shift_ff <= s8_shift_ff;
         s9_tout_ff  <= s8_tout_ff;

         if (hfin[31]) begin
            s10_hout_ff <= '0;
         end else if (hfin > tphc_pkg::HUM_MAX) begin
            s10_hout_ff <= tphc_pkg::HUM_MAX[28:12];
         end else begin
            s10_hout_ff <= hfin[28:12];
         end
         s10_den_ff   <= s9_den_ff;
         s10_num_ff   <= s9_num_ff;
         s10_shift_ff <= s9_shift_ff;
         s10_tout_ff  <= s9_tout_ff;
      end
   end

   assign out_valid = valid_ff[9];
   assign out_num   = s10_num_ff;
   assign out_den   = s10_den_ff;
   assign out_shift = s10_shift_ff;
   assign out_tout  = s10_tout_ff;
   assign out_hout  = s10_hout_ff;

endmodule

// ===== design/tphc_divider.sv =====
// ----------------------------------------------------------------------------
// tphc_divider
// Pipelined restoring divider, one quotient bit per stage, with a side
// payload that travels alongside.
// ----------------------------------------------------------------------------
module tphc_divider #(
   parameter int unsigned SIDE_WIDTH = 35
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [tphc_pkg::DIV_WIDTH-1:0]       in_num,
   input  logic [tphc_pkg::DIV_WIDTH-1:0]       in_den,
   input  logic [SIDE_WIDTH-1:0]                in_side,
   output logic                                 out_valid,
   output logic [tphc_pkg::DIV_WIDTH-1:0]       out_quo,
   output logic [SIDE_WIDTH-1:0]                out_side
);

   localparam int unsigned W = tphc_pkg::DIV_WIDTH;

   logic [W-1:0]          valid_ff;
   logic [W-1:0]          rem_ff  [W];
   logic [W-1:0]          num_ff  [W];
   logic [W-1:0]          quo_ff  [W];
   logic [W-1:0]          den_ff  [W];
   logic [SIDE_WIDTH-1:0] side_ff [W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[W-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < W; i++) begin : g_step
      logic [W-1:0] rem_prev, num_prev, quo_prev, den_prev;
      logic [W-1:0] side_unused;
      logic [W:0]   trial;
      logic [W:0]   diff;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = in_num;
         assign quo_prev = '0;
         assign den_prev = in_den;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign num_prev = num_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign den_prev = den_ff[i-1];
      end
      assign side_unused = '0;

      assign trial = {rem_prev, num_prev[W-1]};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[W]) begin
               rem_ff[i] <= diff[W-1:0];
               quo_ff[i] <= {quo_prev[W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= trial[W-1:0];
               quo_ff[i] <= {quo_prev[W-2:0], 1'b0};
            end
            num_ff[i]  <= {num_prev[W-2:0], 1'b0} | side_unused;
            den_ff[i]  <= den_prev;
            side_ff[i] <= (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_quo   = quo_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule
